[rtl/core/slfr_pkg.sv]
// Shared types and constants for the sync/length frame receiver.
// No dependencies; used by every module in rtl/core.
package slfr_pkg;

	// register map (word index = paddr[3:2])
	localparam int unsigned ADDR_W = 4;
	localparam logic [1:0] REG_SYNC    = 2'd0;
	localparam logic [1:0] REG_MIN_LEN = 2'd1;
	localparam logic [1:0] REG_MAX_LEN = 2'd2;

	localparam logic [7:0] SYNC_RST    = 8'hAA;
	localparam logic [7:0] MIN_LEN_RST = 8'd4;
	localparam logic [7:0] MAX_LEN_RST = 8'd200;

	localparam logic [7:0] COUNT_MAX = 8'd255;

	// frame error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_SYNC   = 2'd1;
	localparam logic [1:0] ERR_LENGTH = 2'd2;

	typedef struct packed {
		logic [7:0] sync_byte;
		logic [7:0] min_length;
		logic [7:0] max_length;
	} cfg_t;

	typedef struct packed {
		logic       stored;
		logic [7:0] index;
		logic [7:0] value;
		logic       done;
		logic [1:0] error;
		logic       ready;
	} res_t;

endpackage

[rtl/core/slfr_regs.sv]
// APB configuration registers of the frame receiver.
// Depends on slfr_pkg (register map, cfg_t).
module slfr_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [slfr_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output slfr_pkg::cfg_t               cfg
);
	import slfr_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_byte  <= SYNC_RST;
			cfg_q.min_length <= MIN_LEN_RST;
			cfg_q.max_length <= MAX_LEN_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SYNC:    cfg_q.sync_byte  <= pwdata[7:0];
				REG_MIN_LEN: cfg_q.min_length <= pwdata[7:0];
				REG_MAX_LEN: cfg_q.max_length <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SYNC:    prdata = {24'd0, cfg_q.sync_byte};
			REG_MIN_LEN: prdata = {24'd0, cfg_q.min_length};
			REG_MAX_LEN: prdata = {24'd0, cfg_q.max_length};
			default:     prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

[rtl/core/slfr_fsm.sv]
// Frame parser: phase state, byte counter, target length, ready level.
// Depends on slfr_pkg (cfg_t, res_t, error codes).
module slfr_fsm (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     rx_byte,
	input  slfr_pkg::cfg_t cfg,
	output slfr_pkg::res_t res
);
	import slfr_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEAD,
		PH_SIZE,
		PH_DATA
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] count_q, count_d;
	logic [7:0] target_q, target_d;
	logic       ready_q, ready_d;
	logic [7:0] count_inc;

	assign count_inc = count_q + 8'd1;

	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		target_d = target_q;
		ready_d  = ready_q;
		res      = '0;
		case (phase_q)
			PH_IDLE: begin
				if (rx_byte == cfg.sync_byte) begin
					ready_d    = 1'b0;
					target_d   = 8'd0;
					res.stored = 1'b1;
					count_d    = 8'd1;
					phase_d    = PH_HEAD;
				end
			end
			PH_HEAD: begin
				if (rx_byte == cfg.sync_byte) begin
					res.stored = 1'b1;
					res.index  = count_q;
					count_d    = count_inc;
					phase_d    = PH_SIZE;
				end else begin
					res.error = ERR_SYNC;
					phase_d   = PH_IDLE;
				end
			end
			PH_SIZE: begin
				if (rx_byte > cfg.max_length || rx_byte < cfg.min_length) begin
					res.error = ERR_LENGTH;
					phase_d   = PH_IDLE;
				end else begin
					target_d   = rx_byte;
					res.stored = 1'b1;
					res.index  = count_q;
					count_d    = count_inc;
					phase_d    = PH_DATA;
				end
			end
			PH_DATA: begin
				res.stored = 1'b1;
				res.index  = count_q;
				// counter saturates at its top value
				if (count_q != COUNT_MAX) count_d = count_inc;
				if (target_q <= count_d) begin
					res.done = 1'b1;
					ready_d  = 1'b1;
					phase_d  = PH_IDLE;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
		res.value = res.stored ? rx_byte : 8'd0;
		res.ready = ready_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			count_q  <= 8'd0;
			target_q <= 8'd0;
			ready_q  <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			target_q <= target_d;
			ready_q  <= ready_d;
		end
	end

endmodule

[rtl/core/sync_length_frame_receiver_core.sv]
// Sync/length frame receiver, top level; depends on slfr_pkg, slfr_regs, slfr_fsm.
// Path: a word is captured in the input register, then moves into the result
// register once that register is free or draining (out_ready low stalls it).
// Throughput: one word per cycle while out_ready is not holding the result
// register; parser state updates as a word moves from input to result register.
// Reset (arst_n low, async): parser idle and cleared, config 0xAA / 4 / 200.
module sync_length_frame_receiver_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// APB config port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [slfr_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// received byte stream
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  rx_byte,
	// per-byte result stream
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        byte_stored,
	output logic [7:0]                  byte_index,
	output logic [7:0]                  byte_value,
	output logic                        frame_done,
	output logic [1:0]                  frame_error,
	output logic                        frame_ready
);
	import slfr_pkg::*;

	cfg_t       cfg;
	res_t       res_c;
	res_t       res_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	logic       adv;

	slfr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// word in stage 1 moves on when the result register is free or draining
	assign adv      = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	// parser steps exactly once per word handed to the result register
	slfr_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.res     (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_c;
		end
	end

	assign out_valid   = out_valid_q;
	assign byte_stored = res_q.stored;
	assign byte_index  = res_q.index;
	assign byte_value  = res_q.value;
	assign frame_done  = res_q.done;
	assign frame_error = res_q.error;
	assign frame_ready = res_q.ready;

endmodule
